>>> rtl/u2a_pkg.sv
// u2a_pkg: shared constants, result type and decode helpers for the
// utf-8 to atascii decoder. No dependencies.
`default_nettype none

package u2a_pkg;

    localparam int BYTE_W  = 8;
    localparam int ACCUM_W = 16;
    localparam int LEFT_W  = 3;

    localparam logic [BYTE_W-1:0]  LINE_FEED   = 8'h0a;
    localparam logic [BYTE_W-1:0]  ATASCII_EOL = 8'd155;
    localparam logic [BYTE_W-1:0]  HIGH_BIT    = 8'h80;
    localparam logic [5:0]         CONT_MASK   = 6'h3f;
    localparam logic [ACCUM_W-1:0] CHECK_MASK  = 16'hfc80;
    localparam logic [ACCUM_W-1:0] CHECK_VALUE = 16'he080;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] out_char;
        logic              char_valid;
        logic              truncated;
        logic              stream_done;
    } t_u2a_result;

    // count of 1 bits directly below bit 7, scanning downward
    function automatic logic [LEFT_W-1:0] lead_count(input logic [BYTE_W-1:0] b);
        logic [LEFT_W-1:0] n;
        logic              run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 2; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + LEFT_W'(1);
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    // payload bits left in a lead byte; leads 0xfe and 0xff carry none
    function automatic logic [BYTE_W-1:0] payload_mask(input logic [LEFT_W-1:0] n);
        logic [BYTE_W-1:0] m;
        case (n)
            3'd0:    m = 8'h3f;
            3'd1:    m = 8'h1f;
            3'd2:    m = 8'h0f;
            3'd3:    m = 8'h07;
            3'd4:    m = 8'h03;
            3'd5:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // accumulated code maps to a character: bits 15:10 and bit 7 match CHECK_VALUE
    function automatic logic code_matches(input logic [ACCUM_W-1:0] acc);
        return (acc & CHECK_MASK) == CHECK_VALUE;
    endfunction

endpackage

`default_nettype wire

>>> rtl/u2a_decode.sv
// u2a_decode: sequence state registers and the per-byte decode logic.
// Depends on u2a_pkg.
`default_nettype none

module u2a_decode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [u2a_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                       i_stream_end,
    output u2a_pkg::t_u2a_result            o_result,
    output logic                            o_has_result
);
    import u2a_pkg::*;

    logic [LEFT_W-1:0]  r_left, n_left;
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [LEFT_W-1:0]  lead_n;
    logic [ACCUM_W-1:0] acc_next;
    logic [LEFT_W-1:0]  left_next;
    logic               have_char;
    logic [BYTE_W-1:0]  ch;

    assign lead_n = lead_count(i_in_byte);

    // classify the byte and update the code accumulator
    always_comb begin
        acc_next  = r_accum;
        left_next = r_left;
        have_char = 1'b0;
        ch        = '0;
        if (r_left != '0) begin
            acc_next  = {r_accum[ACCUM_W-7:0], i_in_byte[5:0] & CONT_MASK};
            left_next = r_left - LEFT_W'(1);
            if (left_next == '0 && code_matches(acc_next)) begin
                have_char = 1'b1;
                ch        = acc_next[BYTE_W-1:0];
            end
        end else if (i_in_byte == LINE_FEED) begin
            have_char = 1'b1;
            ch        = ATASCII_EOL;
        end else if (i_in_byte < HIGH_BIT) begin
            have_char = 1'b1;
            ch        = i_in_byte;
        end else begin
            acc_next  = ACCUM_W'(i_in_byte & payload_mask(lead_n));
            left_next = lead_n;
            if (lead_n == '0 && code_matches(acc_next)) begin
                have_char = 1'b1;
                ch        = acc_next[BYTE_W-1:0];
            end
        end
    end

    // end of stream flags truncation and clears the sequence state
    always_comb begin
        n_accum              = acc_next;
        n_left               = left_next;
        o_result.out_char    = ch;
        o_result.char_valid  = have_char;
        o_result.truncated   = i_stream_end && (left_next != '0);
        o_result.stream_done = i_stream_end;
        if (i_stream_end) begin
            n_accum = '0;
            n_left  = '0;
        end
    end

    assign o_has_result = have_char || i_stream_end;

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_accum <= '0;
        end else if (i_advance) begin
            r_left  <= n_left;
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/u2a_out_reg.sv
// u2a_out_reg: result register holding one transaction until the sink takes it.
// Depends on u2a_pkg.
`default_nettype none

module u2a_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire u2a_pkg::t_u2a_result i_result,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output u2a_pkg::t_u2a_result      o_result
);
    import u2a_pkg::*;

    logic        r_valid;
    t_u2a_result r_result;

    // valid flag: set on load, cleared when the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

>>> rtl/utf8_to_atascii_decoder_unit.sv
// utf8_to_atascii_decoder_unit: one utf-8 byte per transaction in, atascii out.
// Accepted bytes go through the input register into the decode, which loads the
// result register when the held byte advances. Throughput: one byte per cycle,
// unless a byte with a result waits on a full, stalled result register.
// Bytes that give no result are consumed without touching the output side.
// Reset: synchronous active low, clears both valid flags and sequence state.
// Depends on u2a_pkg, u2a_decode and u2a_out_reg.
`default_nettype none

module utf8_to_atascii_decoder_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [u2a_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                       i_stream_end,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [u2a_pkg::BYTE_W-1:0]      o_out_char,
    output logic                            o_char_valid,
    output logic                            o_truncated,
    output logic                            o_stream_done
);
    import u2a_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    logic              advance;
    logic              has_result;
    t_u2a_result       dec_result;
    t_u2a_result       out_result;

    // held byte moves on when it has no result or the result register frees up
    assign advance    = r_in_valid && (!has_result || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_stream_end;
        end
    end

    // decode
    u2a_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_in_byte    (r_in_byte),
        .i_stream_end (r_in_end),
        .o_result     (dec_result),
        .o_has_result (has_result)
    );

    // result register
    u2a_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && has_result),
        .i_result    (dec_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_out_char    = out_result.out_char;
    assign o_char_valid  = out_result.char_valid;
    assign o_truncated   = out_result.truncated;
    assign o_stream_done = out_result.stream_done;

endmodule

`default_nettype wire

>>> tb/utf8_to_atascii_decoder_unit_test.sv
// testbench for utf8_to_atascii_decoder_unit: directed and random utf-8 byte streams
// with random idling, checked against an in-bench decoder model.
// Depends on u2a_pkg and the decoder rtl.
`default_nettype none

module utf8_to_atascii_decoder_unit_test;

    import u2a_pkg::*;

    localparam int RANDOM_BYTES = 1900;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    // decoder model and store of expected result transactions
    class u2a_scoreboard;
        logic [LEFT_W-1:0]  cont_left;
        logic [ACCUM_W-1:0] code;
        t_u2a_result        expected_q[$];
        int unsigned        errors;
        int unsigned        bytes_seen;
        int unsigned        results_seen;
        int unsigned        chars_seen;
        int unsigned        ends_seen;
        int unsigned        truncs_seen;

        function new();
            cont_left    = '0;
            code         = '0;
            errors       = 0;
            bytes_seen   = 0;
            results_seen = 0;
            chars_seen   = 0;
            ends_seen    = 0;
            truncs_seen  = 0;
        endfunction

        function logic is_char(logic [ACCUM_W-1:0] acc);
            return (acc & CHECK_MASK) == CHECK_VALUE;
        endfunction

        // accepted input byte: advance the decoder and queue any result
        function void note_input(logic [BYTE_W-1:0] b, logic last);
            t_u2a_result      r;
            logic             emit;
            logic [LEFT_W-1:0] run;
            r    = '0;
            emit = 1'b0;
            bytes_seen++;
            if (cont_left != 0) begin
                // inside a sequence every byte is a continuation byte
                code      = {code[ACCUM_W-7:0], b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == 0 && is_char(code)) begin
                    emit       = 1'b1;
                    r.out_char = code[7:0];
                end
            end else if (b == LINE_FEED) begin
                emit       = 1'b1;
                r.out_char = ATASCII_EOL;
            end else if (!b[7]) begin
                emit       = 1'b1;
                r.out_char = b;
            end else begin
                // lead byte, or a stray continuation when the run is zero
                run = '0;
                for (int i = 6; i >= 0 && b[i]; i--) begin
                    run = run + 1'b1;
                end
                code      = {8'h00, b & ((run < 6) ? (8'h3f >> run) : 8'h00)};
                cont_left = run;
                if (run == 0 && is_char(code)) begin
                    emit       = 1'b1;
                    r.out_char = code[7:0];
                end
            end
            if (last) begin
                r.truncated   = (cont_left != 0);
                r.stream_done = 1'b1;
                cont_left     = '0;
                code          = '0;
                ends_seen++;
                if (r.truncated) begin
                    truncs_seen++;
                end
            end
            r.char_valid = emit;
            if (emit) begin
                chars_seen++;
            end
            if (emit || last) begin
                expected_q.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // accepted result: compare with the oldest expectation
        task check_result(t_u2a_result got);
            t_u2a_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result char=%02h valid=%b trunc=%b done=%b",
                                 got.out_char, got.char_valid, got.truncated,
                                 got.stream_done));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (got.out_char !== want.out_char) begin
                report($sformatf("out_char %02h, expected %02h", got.out_char, want.out_char));
            end
            if (got.char_valid !== want.char_valid) begin
                report($sformatf("char_valid %b, expected %b", got.char_valid,
                                 want.char_valid));
            end
            if (got.truncated !== want.truncated) begin
                report($sformatf("truncated %b, expected %b", got.truncated, want.truncated));
            end
            if (got.stream_done !== want.stream_done) begin
                report($sformatf("stream_done %b, expected %b", got.stream_done,
                                 want.stream_done));
            end
        endtask
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [BYTE_W-1:0] i_in_byte    = '0;
    logic              i_stream_end = 1'b0;
    logic              i_out_stall  = 1'b0;
    wire logic         o_in_stall;
    wire logic         o_out_valid;
    wire logic [BYTE_W-1:0] o_out_char;
    wire logic         o_char_valid;
    wire logic         o_truncated;
    wire logic         o_stream_done;

    u2a_scoreboard     sb;
    logic [8:0]        stim_q[$];
    logic              quiet_phase = 1'b0;
    int unsigned       idle_cycles = 0;

    utf8_to_atascii_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_stream_end  (i_stream_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_truncated   (o_truncated),
        .o_stream_done (o_stream_done)
    );

    always #2 i_clk = ~i_clk;

    // stimulus building
    task automatic push_byte(logic [BYTE_W-1:0] b, logic last);
        stim_q.push_back({last, b});
    endtask

    function automatic logic random_end();
        return $urandom_range(0, 39) == 0;
    endfunction

    // continuation byte; top bits are not checked, so vary them now and then
    function automatic logic [BYTE_W-1:0] cont_byte(logic [5:0] p);
        logic [1:0] top;
        top = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b10;
        return {top, p};
    endfunction

    // sequence with n continuation bytes whose low 16 bits decode to a character
    task automatic add_char_sequence(int n);
        logic [BYTE_W-1:0] lead;
        logic [5:0]        p;
        if (n == 2) begin
            lead = 8'hee;
        end else begin
            lead = ~(8'hff >> (n + 1)) | (8'($urandom) & (8'h3f >> n));
        end
        push_byte(lead, random_end());
        for (int i = 0; i < n; i++) begin
            p = 6'($urandom);
            if (i == n - 3) begin
                p[3:0] = 4'he;
            end
            if (i == n - 2) begin
                p[5:4] = 2'b00;
                p[1]   = 1'b1;
            end
            push_byte(cont_byte(p), random_end());
        end
    endtask

    // lead with n continuation bytes of random content
    task automatic add_random_sequence(int n);
        push_byte(~(8'hff >> (n + 1)) | (8'($urandom) & (8'h3f >> n)), random_end());
        for (int i = 0; i < n; i++) begin
            push_byte(8'($urandom), random_end());
        end
    endtask

    task automatic build_stimulus();
        int unsigned pick;
        // plain bytes at the extremes, line feed, stray continuation bytes
        push_byte(8'h00, 1'b0);
        push_byte(LINE_FEED, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hbf, 1'b0);
        // three-byte sequence that decodes
        push_byte(8'hee, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hbf, 1'b0);
        // lead 0xfe, line feed and plain bytes taken as continuations
        push_byte(8'hfe, 1'b0);
        push_byte(LINE_FEED, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(LINE_FEED, 1'b0);
        push_byte(8'h8e, 1'b0);
        push_byte(8'h83, 1'b0);
        push_byte(8'hff, 1'b0);
        // lead 0xff, accumulator keeps only the low 16 bits
        push_byte(8'hff, 1'b0);
        for (int i = 0; i < 4; i++) begin
            push_byte(8'h00, 1'b0);
        end
        push_byte(8'h4e, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h40, 1'b0);
        // stream ends on a lead, on a plain byte, mid-sequence, on a completing byte
        push_byte(8'he2, 1'b1);
        push_byte(8'h41, 1'b1);
        push_byte(8'hee, 1'b0);
        push_byte(8'h82, 1'b1);
        push_byte(8'hee, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h81, 1'b1);
        push_byte(8'h90, 1'b1);

        // random part: mostly well-formed sequences, some noise
        for (int target = stim_q.size() + RANDOM_BYTES; stim_q.size() < target; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_byte(($urandom_range(0, 7) == 0) ? LINE_FEED : 8'($urandom_range(0, 127)),
                          random_end());
            end else if (pick < 60) begin
                add_char_sequence(($urandom_range(0, 1) == 0) ? 2 : $urandom_range(3, 7));
            end else if (pick < 80) begin
                add_random_sequence($urandom_range(1, 7));
            end else if (pick < 90) begin
                push_byte(8'($urandom_range(8'h80, 8'hbf)), random_end());
            end else begin
                push_byte(8'($urandom), random_end());
            end
        end
    endtask

    // sender: random gaps, none in the quiet stretches
    task automatic drive_stream();
        int unsigned gap;
        for (int idx = 0; idx < stim_q.size(); idx++) begin
            quiet_phase = (idx >= 400 && idx < 600) || (idx >= 1300 && idx < 1450);
            gap = quiet_phase ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_in_byte    <= stim_q[idx][7:0];
            i_stream_end <= stim_q[idx][8];
            do @(posedge i_clk); while (o_in_stall !== 1'b0);
            sb.note_input(stim_q[idx][7:0], stim_q[idx][8]);
        end
        i_in_valid <= 1'b0;
    endtask

    // receiver: random stall per transaction, two long hold-offs
    initial begin
        int unsigned n;
        int unsigned k;
        k = 0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (k == 60 || k == 400) begin
                n = HOLD_CYCLES;
            end else begin
                n = quiet_phase ? 0 : $urandom_range(0, 3);
            end
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            k++;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_result('{out_char: o_out_char, char_valid: o_char_valid,
                              truncated: o_truncated, stream_done: o_stream_done});
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        sb = new();
        build_stimulus();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_stream();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d bytes and %0d results: %0d characters, %0d stream ends, %0d truncated",
                 sb.bytes_seen, sb.results_seen, sb.chars_seen, sb.ends_seen, sb.truncs_seen);
        $display("with random idling on both sides, quiet stretches and two long output hold-offs");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/u2a_pkg.sv
rtl/u2a_decode.sv
rtl/u2a_out_reg.sv
rtl/utf8_to_atascii_decoder_unit.sv
tb/utf8_to_atascii_decoder_unit_test.sv
